/* rtl/core/deq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg: shared definitions for the double-ended queue
// Opcodes, status codes, default sizes and the types passed between the
// controller, the storage cells and the result buffer.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    // Widths of the request and result fields.
    localparam int OPCODE_BITS = 3;
    localparam int VALUE_BITS  = 32;

    localparam logic [OPCODE_BITS-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_BITS-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_BITS-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_BITS-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_BITS-1:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [OPCODE_BITS-1:0] OP_PEEK_BACK  = 3'd5;
    localparam logic [OPCODE_BITS-1:0] OP_CLEAR      = 3'd6;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
        logic clear;
        logic rd_load;
        logic rd_shift;
    } t_cell_cmd;

    typedef struct packed {
        logic                  status;
        logic [VALUE_BITS-1:0] read_value;
    } t_result;

endpackage

/* rtl/core/deq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_if: request and result channels of the double-ended queue
// Valid/ready channels; an item moves on a rising edge with both high.
// ----------------------------------------------------------------------------
interface deq_req_if;
    logic                              valid;
    logic                              ready;
    logic [deq_pkg::OPCODE_BITS-1:0]   opcode;
    logic [deq_pkg::VALUE_BITS-1:0]    push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              status;
    logic [deq_pkg::VALUE_BITS-1:0]    read_value;

    modport source (output valid, output status, output read_value, input ready);
    modport sink   (input valid, input status, input read_value, output ready);
endinterface

/* rtl/core/deq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_cell: one storage position of the queue chain
// Holds one word and its occupancy bit, shifts with its neighbours and
// takes part in the back-read chain that carries the back word to cell 0.
// ----------------------------------------------------------------------------
module deq_cell #(
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  deq_pkg::t_cell_cmd    i_cmd,
    input  logic [WORD_BITS-1:0]  i_word,
    input  logic                  i_left_valid,
    input  logic [WORD_BITS-1:0]  i_left_data,
    input  logic                  i_right_valid,
    input  logic [WORD_BITS-1:0]  i_right_data,
    input  logic                  i_right_rd_hit,
    input  logic [WORD_BITS-1:0]  i_right_rd_data,
    output logic                  o_valid,
    output logic [WORD_BITS-1:0]  o_data,
    output logic                  o_rd_hit,
    output logic [WORD_BITS-1:0]  o_rd_data
);

    logic                 r_valid, n_valid;
    logic [WORD_BITS-1:0] r_data, n_data;
    logic                 r_rd_hit, n_rd_hit;
    logic [WORD_BITS-1:0] r_rd_data, n_rd_data;
    logic                 w_is_back;

    // The back cell is the last occupied one.
    assign w_is_back = r_valid && !i_right_valid;

    always_comb begin
        n_valid   = r_valid;
        n_data    = r_data;
        n_rd_hit  = r_rd_hit;
        n_rd_data = r_rd_data;
        if (i_cmd.push_front) begin
            n_valid = i_left_valid;
            n_data  = i_left_data;
        end
        if (i_cmd.push_back && !r_valid && i_left_valid) begin
            n_valid = 1'b1;
            n_data  = i_word;
        end
        if (i_cmd.pop_front) begin
            n_valid = i_right_valid;
            n_data  = i_right_data;
        end
        if (i_cmd.pop_back && w_is_back) begin
            n_valid = 1'b0;
        end
        if (i_cmd.clear) begin
            n_valid = 1'b0;
        end
        if (i_cmd.rd_load) begin
            n_rd_hit  = w_is_back;
            n_rd_data = r_data;
        end
        if (i_cmd.rd_shift) begin
            n_rd_hit  = i_right_rd_hit;
            n_rd_data = i_right_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_rd_hit <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_rd_hit <= n_rd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data    <= n_data;
        r_rd_data <= n_rd_data;
    end

    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_rd_hit  = r_rd_hit;
    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/deq_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_out_buf: two-entry result buffer
// Decouples the result channel so that a new request can be taken while an
// earlier result is still waiting.
// ----------------------------------------------------------------------------
module deq_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  deq_pkg::t_result  i_result,
    output logic              o_space,
    deq_rsp_if.source         o_rsp
);

    localparam logic [1:0] BUF_ENTRIES = 2'd2;

    logic [1:0]        r_cnt, n_cnt;
    deq_pkg::t_result  r_q0, n_q0;
    deq_pkg::t_result  r_q1, n_q1;
    logic              w_pop;
    logic [1:0]        w_slot;

    assign w_pop  = o_rsp.valid && o_rsp.ready;
    assign w_slot = r_cnt - {1'b0, w_pop};

    always_comb begin
        n_q0  = w_pop ? r_q1 : r_q0;
        n_q1  = r_q1;
        n_cnt = w_slot + {1'b0, i_push};
        if (i_push) begin
            if (w_slot == 2'd0) begin
                n_q0 = i_result;
            end else begin
                n_q1 = i_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_space          = (r_cnt != BUF_ENTRIES);
    assign o_rsp.valid      = (r_cnt != 2'd0);
    assign o_rsp.status     = r_q0.status;
    assign o_rsp.read_value = r_q0.read_value;

endmodule

/* rtl/core/double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: double-ended queue of fixed-width words
// A row of DEPTH identical cells holds the queue with its front in cell 0;
// a small controller decodes requests and a two-entry buffer returns results.
// ----------------------------------------------------------------------------
// Every request (push front, push back, pop front, pop back, peek front, peek
// back, clear) returns exactly one result with an ok or error status and, for
// a successful peek, the word read. Pushes, pops, peek front and clear are
// finished when taken, so such requests may follow one another in every
// cycle while the result buffer has room. Peek back is slower: the back
// word travels towards cell 0 along a registered read chain through the
// cells, one cell per cycle, and no request is taken meanwhile.
// Results wait in a two-entry buffer, so one further request can be taken
// while the result channel stalls. After reset the queue is empty at once;
// no clearing pass is needed. Stored words keep the low WORD_BITS bits of
// push_value, and read_value carries the low 32 bits of a word, zero-padded.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH     = deq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = deq_pkg::WORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    localparam int VB = deq_pkg::VALUE_BITS;

    // Controller states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                 r_state, n_state;
    deq_pkg::t_cell_cmd   w_cmd;
    logic                 w_accept;
    logic                 w_out_space;
    logic                 w_res_valid;
    deq_pkg::t_result     w_result;
    logic                 w_empty, w_full;

    logic [WORD_BITS-1:0] w_word;
    logic [VB-1:0]        w_front_ext, w_back_ext;

    // Chain signals, one element per cell; cell 0 holds the front.
    logic [DEPTH-1:0]     w_valid;
    logic [DEPTH-1:0]     w_rd_hit;
    logic [WORD_BITS-1:0] w_data    [DEPTH];
    logic [WORD_BITS-1:0] w_rd_data [DEPTH];

    // Occupancy is a run of ones from cell 0, so the ends of that run tell
    // whether the queue is empty or full.
    assign w_empty = !w_valid[0];
    assign w_full  = w_valid[DEPTH-1];

    // Word width conversions between the fixed 32-bit ports and the cells.
    generate
        if (WORD_BITS <= VB) begin : g_in_narrow
            assign w_word = i_req.push_value[WORD_BITS-1:0];
        end else begin : g_in_wide
            assign w_word = {{(WORD_BITS - VB){1'b0}}, i_req.push_value};
        end
        if (WORD_BITS >= VB) begin : g_out_wide
            assign w_front_ext = w_data[0][VB-1:0];
            assign w_back_ext  = w_rd_data[0][VB-1:0];
        end else begin : g_out_narrow
            assign w_front_ext = {{(VB - WORD_BITS){1'b0}}, w_data[0]};
            assign w_back_ext  = {{(VB - WORD_BITS){1'b0}}, w_rd_data[0]};
        end
    endgenerate

    // Requests are taken only in the idle state and only with room for
    // the result, so a result always finds a free buffer entry.
    assign i_req.ready = (r_state == S_IDLE) && w_out_space;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state             = r_state;
        w_cmd               = '0;
        w_res_valid         = 1'b0;
        w_result.status     = deq_pkg::STATUS_OK;
        w_result.read_value = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_res_valid = 1'b1;
                    case (i_req.opcode)
                        deq_pkg::OP_PUSH_FRONT: begin
                            if (w_full) begin
                                w_result.status = deq_pkg::STATUS_ERROR;
                            end else begin
                                w_cmd.push_front = 1'b1;
                            end
                        end
                        deq_pkg::OP_PUSH_BACK: begin
                            if (w_full) begin
                                w_result.status = deq_pkg::STATUS_ERROR;
                            end else begin
                                w_cmd.push_back = 1'b1;
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (w_empty) begin
                                w_result.status = deq_pkg::STATUS_ERROR;
                            end else begin
                                w_cmd.pop_front = 1'b1;
                            end
                        end
                        deq_pkg::OP_POP_BACK: begin
                            if (w_empty) begin
                                w_result.status = deq_pkg::STATUS_ERROR;
                            end else begin
                                w_cmd.pop_back = 1'b1;
                            end
                        end
                        deq_pkg::OP_PEEK_FRONT: begin
                            if (w_empty) begin
                                w_result.status = deq_pkg::STATUS_ERROR;
                            end else begin
                                w_result.read_value = w_front_ext;
                            end
                        end
                        deq_pkg::OP_PEEK_BACK: begin
                            if (w_empty) begin
                                w_result.status = deq_pkg::STATUS_ERROR;
                            end else begin
                                // The result follows once the back word
                                // has reached cell 0 of the read chain.
                                w_res_valid   = 1'b0;
                                w_cmd.rd_load = 1'b1;
                                n_state       = S_READ;
                            end
                        end
                        deq_pkg::OP_CLEAR: begin
                            w_cmd.clear = 1'b1;
                        end
                        default: begin
                            w_result.status = deq_pkg::STATUS_ERROR;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (w_rd_hit[0]) begin
                    w_res_valid         = 1'b1;
                    w_result.read_value = w_back_ext;
                    n_state             = S_IDLE;
                end else begin
                    w_cmd.rd_shift = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The chain of cells. Cell 0 sees an occupied left neighbour carrying
    // the pushed word, so a push to the front shifts that word in, and a push
    // to the back into an empty queue lands in cell 0. The last cell sees an
    // empty right neighbour.
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic                 left_valid;
            logic [WORD_BITS-1:0] left_data;
            logic                 right_valid;
            logic [WORD_BITS-1:0] right_data;
            logic                 right_rd_hit;
            logic [WORD_BITS-1:0] right_rd_data;

            if (g == 0) begin : g_first
                assign left_valid = 1'b1;
                assign left_data  = w_word;
            end else begin : g_inner_l
                assign left_valid = w_valid[g-1];
                assign left_data  = w_data[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign right_valid   = 1'b0;
                assign right_data    = '0;
                assign right_rd_hit  = 1'b0;
                assign right_rd_data = '0;
            end else begin : g_inner_r
                assign right_valid   = w_valid[g+1];
                assign right_data    = w_data[g+1];
                assign right_rd_hit  = w_rd_hit[g+1];
                assign right_rd_data = w_rd_data[g+1];
            end

            deq_cell #(
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk           (i_clk),
                .i_rst_n         (i_rst_n),
                .i_cmd           (w_cmd),
                .i_word          (w_word),
                .i_left_valid    (left_valid),
                .i_left_data     (left_data),
                .i_right_valid   (right_valid),
                .i_right_data    (right_data),
                .i_right_rd_hit  (right_rd_hit),
                .i_right_rd_data (right_rd_data),
                .o_valid         (w_valid[g]),
                .o_data          (w_data[g]),
                .o_rd_hit        (w_rd_hit[g]),
                .o_rd_data       (w_rd_data[g])
            );
        end
    endgenerate

    deq_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_res_valid),
        .i_result (w_result),
        .o_space  (w_out_space),
        .o_rsp    (o_rsp)
    );

    // Occupied cells always form one run starting at cell 0.
    a_occupancy_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + DEPTH'(1))) == '0))
        else $error("queue occupancy is not a run from cell 0");

    // A result is only ever produced when the buffer has room for it.
    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_out_space)
        else $error("result produced with a full result buffer");

    // The queue occupancy is left alone while the back word is read out.
    a_read_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> $stable(w_valid))
        else $error("occupancy changed during a back read");

endmodule
